// ===== sv/mfbx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfbx_pkg
// Shared types and constants for the framed message builder with an XOR
// checksum.
// ----------------------------------------------------------------------------
package mfbx_pkg;

    localparam int unsigned FRAME_BYTES  = 64;
    localparam int unsigned HEADER_BYTES = 5;

    // Largest payload count whose frame still fits.
    localparam logic [8:0] MAX_FIT_COUNT = 9'(FRAME_BYTES - HEADER_BYTES - 1);

    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_MODE_BYTE  = 2'd1;
    localparam logic [1:0] CFG_NODE_ID    = 2'd2;

    localparam logic [7:0] RESET_START_BYTE = 8'h02;
    localparam logic [7:0] RESET_MODE_BYTE  = 8'h00;
    localparam logic [7:0] RESET_NODE_ID    = 8'hA1;

    typedef struct packed {
        logic [7:0] msg_type;
        logic [7:0] payload_count;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] mode_byte;
        logic [7:0] node_id;
    } cfg_t;

    // Work left for one accepted transaction that produces output.
    typedef struct packed {
        logic       is_header;
        logic       with_data;
        logic       with_check;
        logic [7:0] msg_type;
        logic [7:0] payload_count;
        logic [7:0] data_byte;
    } plan_t;

    typedef enum logic [6:0] {
        ST_START = 7'b0000001,
        ST_MODE  = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_SIG   = 7'b0001000,
        ST_TYPE  = 7'b0010000,
        ST_DATA  = 7'b0100000,
        ST_CHECK = 7'b1000000
    } step_t;

endpackage
`default_nettype wire

// ===== sv/mfbx_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfbx_cfg
// Configuration registers for the frame header bytes.
// ----------------------------------------------------------------------------
module mfbx_cfg
    import mfbx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_BYTE: cfg_next.start_byte = cfg_data;
                CFG_MODE_BYTE:  cfg_next.mode_byte  = cfg_data;
                CFG_NODE_ID:    cfg_next.node_id    = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte <= RESET_START_BYTE;
            cfg_reg.mode_byte  <= RESET_MODE_BYTE;
            cfg_reg.node_id    <= RESET_NODE_ID;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mfbx_admit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfbx_admit
// Message tracking at the input: counts payload bytes, decides whether a
// message is framed or dropped, and hands a plan for each transaction that
// produces output to the emitter.
// ----------------------------------------------------------------------------
module mfbx_admit
    import mfbx_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     accept,
    input  wire in_item_t item,
    output logic          load,
    output plan_t         plan
);

    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       dropping_reg;
    logic       dropping_next;
    logic [7:0] left_dec;
    logic [7:0] count_dec;
    logic       too_big;

    assign left_dec  = bytes_left_reg - 8'd1;
    assign count_dec = item.payload_count - 8'd1;
    assign too_big   = {1'b0, item.payload_count} > MAX_FIT_COUNT;

    always_comb begin
        bytes_left_next     = bytes_left_reg;
        dropping_next       = dropping_reg;
        load                = 1'b0;
        plan.is_header      = 1'b0;
        plan.with_data      = 1'b1;
        plan.with_check     = 1'b0;
        plan.msg_type       = item.msg_type;
        plan.payload_count  = item.payload_count;
        plan.data_byte      = item.data_byte;
        if (accept) begin
            if (bytes_left_reg != 8'd0) begin
                bytes_left_next = left_dec;
                if (dropping_reg) begin
                    dropping_next = (left_dec != 8'd0);
                end else begin
                    load            = 1'b1;
                    plan.with_check = (left_dec == 8'd0);
                end
            end else if (too_big) begin
                bytes_left_next = count_dec;
                dropping_next   = (count_dec != 8'd0);
            end else begin
                dropping_next   = 1'b0;
                load            = 1'b1;
                plan.is_header  = 1'b1;
                plan.with_data  = (item.payload_count != 8'd0);
                plan.with_check = (item.payload_count <= 8'd1);
                bytes_left_next = (item.payload_count == 8'd0) ? 8'd0 : count_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 8'd0;
            dropping_reg   <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            dropping_reg   <= dropping_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mfbx_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfbx_emit
// Holds one planned transaction, steps through its header, payload and
// checksum bytes, and drives the registered result channel.
// ----------------------------------------------------------------------------
module mfbx_emit
    import mfbx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  load,
    input  wire plan_t plan,
    output logic       slot_free,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);

    logic      item_valid_reg;
    logic      item_valid_next;
    plan_t     plan_reg;
    step_t     step_reg;
    step_t     step_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_item_t m_data_reg;
    out_item_t byte_out;
    logic      advance;
    logic      last;
    step_t     step_after;

    assign advance   = item_valid_reg && (!m_valid_reg || m_ready);
    assign slot_free = !item_valid_reg || (advance && last);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        byte_out.frame_end = 1'b0;
        byte_out.out_byte  = xor_reg;
        xor_next           = xor_reg;
        last               = 1'b0;
        step_after         = ST_CHECK;
        unique case (step_reg)
            ST_START: begin
                byte_out.out_byte = cfg.start_byte;
                xor_next          = cfg.start_byte;
                step_after        = ST_MODE;
            end
            ST_MODE: begin
                byte_out.out_byte = cfg.mode_byte;
                xor_next          = xor_reg ^ cfg.mode_byte;
                step_after        = ST_LEN;
            end
            ST_LEN: begin
                byte_out.out_byte = plan_reg.payload_count + 8'd1;
                xor_next          = xor_reg ^ (plan_reg.payload_count + 8'd1);
                step_after        = ST_SIG;
            end
            ST_SIG: begin
                byte_out.out_byte = cfg.node_id;
                xor_next          = xor_reg ^ cfg.node_id;
                step_after        = ST_TYPE;
            end
            ST_TYPE: begin
                byte_out.out_byte = plan_reg.msg_type;
                xor_next          = xor_reg ^ plan_reg.msg_type;
                step_after        = plan_reg.with_data ? ST_DATA : ST_CHECK;
            end
            ST_DATA: begin
                byte_out.out_byte = plan_reg.data_byte;
                xor_next          = xor_reg ^ plan_reg.data_byte;
                last              = !plan_reg.with_check;
                step_after        = ST_CHECK;
            end
            ST_CHECK: begin
                byte_out.out_byte  = xor_reg;
                byte_out.frame_end = 1'b1;
                xor_next           = 8'd0;
                last               = 1'b1;
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    always_comb begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        if (advance) begin
            step_next = step_after;
            if (last) begin
                item_valid_next = 1'b0;
            end
        end
        if (load) begin
            item_valid_next = 1'b1;
            step_next       = plan.is_header ? ST_START : ST_DATA;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            step_reg       <= ST_START;
            xor_reg        <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            m_valid_reg    <= m_valid_next;
            if (advance) begin
                xor_reg <= xor_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan;
        end
        if (advance) begin
            m_data_reg <= byte_out;
        end
    end

endmodule
`default_nettype wire

// ===== sv/message_frame_builder_xor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// message_frame_builder_xor
// Builds start/length frames with an XOR checksum from a stream of payload
// bytes, one output byte per transaction on the result channel.
//
//   Channel   Ports                            Carries
//   input     s_valid, s_ready, s_data         in_item_t, one payload byte
//   result    m_valid, m_ready, m_data         out_item_t, one frame byte
//   config    cfg_valid, cfg_ready, cfg_index, 8-bit header register write
//             cfg_data
//
// A payload byte in the middle of a message yields one frame byte, and the last
// one yields two because the checksum follows it. A message start yields the
// five header bytes, its payload byte if any, and the checksum when the frame
// ends there; the emitter walks them one per cycle unless m_ready stalls it.
// Dropped transactions are accepted once the emitter is free and produce
// nothing. Reset is synchronous and clears the message tracking and both
// valid flags. A stall on m_ready freezes the emitter, and the input is
// accepted again as soon as its slot frees.
// ----------------------------------------------------------------------------
module message_frame_builder_xor
    import mfbx_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t  cfg;
    plan_t plan;
    logic  load;
    logic  slot_free;
    logic  accept;

    assign s_ready = slot_free;
    assign accept  = s_valid && slot_free;

    mfbx_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfbx_admit u_admit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .load    (load),
        .plan    (plan)
    );

    mfbx_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .load      (load),
        .plan      (plan),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== bench/message_frame_builder_xor_tb.sv =====
// ----------------------------------------------------------------------------
// message_frame_builder_xor_tb
// Drives payload transactions and header register writes into the frame
// builder. A scoreboard class predicts every framed byte and the frame end
// flag, then compares each result transaction against its prediction. The
// run starts with directed messages and boundary payload counts, then
// continues with random messages under several header settings. Both
// channels idle at random, and the result side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module message_frame_builder_xor_tb;
    import mfbx_pkg::*;

    localparam int unsigned TOTAL_ITEMS      = 300;
    localparam int unsigned PHASE_ITEMS      = 40;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned WATCHDOG_LIMIT   = 3000;
    localparam logic [1:0]  CFG_UNUSED       = 2'd3;

    class frame_checker;
        logic [7:0] start_byte;
        logic [7:0] mode_byte;
        logic [7:0] node_id;
        logic [7:0] bytes_left;
        logic [7:0] running_xor;
        bit         dropping;
        out_item_t  pending_bytes[$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            start_byte   = RESET_START_BYTE;
            mode_byte    = RESET_MODE_BYTE;
            node_id      = RESET_NODE_ID;
            bytes_left   = '0;
            running_xor  = '0;
            dropping     = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [7:0] value);
            case (index)
                CFG_START_BYTE: start_byte = value;
                CFG_MODE_BYTE:  mode_byte = value;
                CFG_NODE_ID:    node_id = value;
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] value);
            pending_bytes.push_back('{out_byte: value, frame_end: 1'b0});
            running_xor = running_xor ^ value;
        endfunction

        function void emit_checksum();
            pending_bytes.push_back('{out_byte: running_xor, frame_end: 1'b1});
            running_xor = '0;
        endfunction

        function void note_input(in_item_t item);
            int unsigned frame_len;
            if (bytes_left != 0) begin
                bytes_left = bytes_left - 8'd1;
                if (dropping) begin
                    if (bytes_left == 0)
                        dropping = 1'b0;
                    return;
                end
                emit(item.data_byte);
                if (bytes_left == 0)
                    emit_checksum();
                return;
            end
            frame_len = item.payload_count + HEADER_BYTES + 1;
            if (frame_len > FRAME_BYTES) begin
                bytes_left = (item.payload_count != 0) ? item.payload_count - 8'd1 : 8'd0;
                dropping = (bytes_left != 0);
                return;
            end
            dropping = 1'b0;
            running_xor = '0;
            emit(start_byte);
            emit(mode_byte);
            emit(item.payload_count + 8'd1);
            emit(node_id);
            emit(item.msg_type);
            if (item.payload_count == 0) begin
                emit_checksum();
                return;
            end
            emit(item.data_byte);
            bytes_left = item.payload_count - 8'd1;
            if (bytes_left == 0)
                emit_checksum();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (pending_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual byte %02h end %b",
                         $time, got.out_byte, got.frame_end);
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, want.out_byte, got.out_byte);
            end
            if (got.frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch, expected %b, actual %b",
                         $time, want.frame_end, got.frame_end);
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_START_BYTE;
    logic [7:0] cfg_data  = '0;

    frame_checker frames = new();
    int unsigned  burst_left   = 0;
    int unsigned  sent_items   = 0;
    int unsigned  quiet_cycles = 0;

    message_frame_builder_xor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                frames.set_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                frames.note_input(s_data);
            if (m_valid && m_ready)
                frames.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned stretch;
        int unsigned style;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            stretch = $urandom_range(10, 150);
            repeat (stretch) begin
                @(posedge aclk);
                if (!long_hold_done && frames.results_seen >= 100 && s_valid) begin
                    long_hold_done = 1'b1;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                end
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic send_item(input in_item_t item);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    task automatic send_message(input logic [7:0] msg_type, input logic [7:0] payload_count,
                                input bit random_data, input logic [7:0] fill);
        in_item_t    item;
        int unsigned steps;
        steps = (payload_count == 0) ? 1 : payload_count;
        for (int unsigned i = 0; i < steps; i++) begin
            item.data_byte = random_data ? 8'($urandom) : fill;
            if (i == 0) begin
                item.msg_type = msg_type;
                item.payload_count = payload_count;
            end else begin
                item.msg_type = 8'($urandom);
                item.payload_count = 8'($urandom);
            end
            send_item(item);
        end
        sent_items += steps;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (frames.pending_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input bit [3:0] mask, input logic [7:0] start_value,
                                input logic [7:0] mode_value, input logic [7:0] id_value,
                                input logic [7:0] spare_value);
        if (mask[CFG_START_BYTE]) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_START_BYTE;
            cfg_data <= start_value;
            do @(posedge aclk); while (!cfg_ready);
        end
        if (mask[CFG_MODE_BYTE]) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_MODE_BYTE;
            cfg_data <= mode_value;
            do @(posedge aclk); while (!cfg_ready);
        end
        if (mask[CFG_NODE_ID]) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_NODE_ID;
            cfg_data <= id_value;
            do @(posedge aclk); while (!cfg_ready);
        end
        if (mask[CFG_UNUSED]) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_UNUSED;
            cfg_data <= spare_value;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_payload_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 8'($urandom_range(0, 6));
        else if (roll < 80)
            return 8'($urandom_range(7, 24));
        else if (roll < 86)
            return 8'(MAX_FIT_COUNT);
        else
            return 8'($urandom_range(59, 63));
    endfunction

    initial begin
        int unsigned phase_target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_message(8'h00, 8'd0, 1'b0, 8'hFF);
        send_message(8'hFF, 8'd0, 1'b0, 8'h00);
        send_message(8'hFF, 8'd1, 1'b0, 8'hFF);
        send_message(8'h00, 8'd1, 1'b0, 8'h00);
        send_message(8'h5A, 8'd2, 1'b0, 8'hA5);
        wait_drained();
        apply_config(4'b1111, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_message(8'h81, 8'd3, 1'b1, 8'h00);
        send_message(8'h7E, 8'd4, 1'b1, 8'h00);
        wait_drained();
        apply_config(4'b1111, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_message(8'h3C, 8'd5, 1'b1, 8'h00);
        send_message(8'($urandom), 8'(MAX_FIT_COUNT), 1'b1, 8'h00);
        send_message(8'($urandom), 8'(MAX_FIT_COUNT) + 8'd1, 1'b1, 8'h00);
        send_message(8'($urandom), 8'd0, 1'b1, 8'h00);

        phase_target = sent_items;
        while (sent_items < TOTAL_ITEMS) begin
            wait_drained();
            apply_config({($urandom_range(0, 4) == 0), ($urandom_range(0, 9) < 7),
                          ($urandom_range(0, 9) < 7), ($urandom_range(0, 9) < 7)},
                         pick_reg_value(), pick_reg_value(), pick_reg_value(),
                         8'($urandom));
            phase_target += PHASE_ITEMS;
            while (sent_items < phase_target)
                send_message(8'($urandom), pick_payload_count(), 1'b1, 8'h00);
        end
        wait_drained();

        if (frames.pending_bytes.size() != 0) begin
            frames.errors++;
            $display("%0t: %0d expected results never arrived",
                     $time, frames.pending_bytes.size());
        end
        if (frames.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
